// File: hdl/sda_pkg.sv
`default_nettype none

package sda_pkg;

    localparam int COORD_W     = 32;
    localparam int RADIUS_W    = 48;
    localparam int ACC_W       = 64;
    localparam int GAIN_W      = 32;
    localparam int GAIN_FRAC   = 16;
    localparam int LIMB_W      = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int REG_IDX_W   = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_RADIUS_SQ     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_OFFSET = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DENSITY_GAIN  = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] own_x;
        logic signed [COORD_W-1:0] own_y;
        logic signed [COORD_W-1:0] own_z;
        logic signed [COORD_W-1:0] neighbour_x;
        logic signed [COORD_W-1:0] neighbour_y;
        logic signed [COORD_W-1:0] neighbour_z;
        logic                      first_pair;
        logic                      last_pair;
    } sda_pair_t;

    typedef struct packed {
        logic [ACC_W-1:0] density;
        logic             saturated;
    } sda_result_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } sda_cfg_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius_sq;
        logic [ACC_W-1:0]    kernel_offset;
        logic [GAIN_W-1:0]   density_gain;
    } sda_cfg_regs_t;

    // One classified pair handed from front to back
    typedef struct packed {
        logic [RADIUS_W-1:0] h;
        logic                term_ok;
        logic                is_first;
        logic                is_last;
    } sda_term_t;

    typedef struct packed {
        logic      valid;
        sda_term_t term;
    } sda_qpush_t;

    typedef struct packed {
        logic      valid;
        sda_term_t term;
    } sda_qhead_t;

endpackage

`default_nettype wire

// File: hdl/sda_stream_if.sv
`default_nettype none

interface sda_stream_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/sda_front.sv
`default_nettype none

module sda_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [sda_pkg::RADIUS_W-1:0]  radius_sq,
    sda_stream_if.sink                         pair_in,
    input  wire logic                          q_full,
    output sda_pkg::sda_qpush_t                push
);

    localparam int SQ_W  = 2 * sda_pkg::COORD_W;
    localparam int D2_W  = SQ_W + 2;

    logic                          advance;
    logic                          s1_valid_reg;
    logic [sda_pkg::COORD_W-1:0]   s1_mag_reg [0:2];
    logic [sda_pkg::COORD_W-1:0]   mag_next   [0:2];
    logic                          s2_valid_reg;
    logic [SQ_W-1:0]               s2_sq_reg  [0:2];
    logic [D2_W-1:0]               dist2;
    logic                          in_range;

    function automatic logic [sda_pkg::COORD_W-1:0] abs_diff(
        input logic signed [sda_pkg::COORD_W-1:0] a,
        input logic signed [sda_pkg::COORD_W-1:0] b
    );
        logic signed [sda_pkg::COORD_W:0] d;
        d = {a[sda_pkg::COORD_W-1], a} - {b[sda_pkg::COORD_W-1], b};
        return d[sda_pkg::COORD_W] ? (~d[sda_pkg::COORD_W-1:0] + 1'b1)
                                   : d[sda_pkg::COORD_W-1:0];
    endfunction

    // Hold the whole pipe while the oldest pair cannot enter the queue
    assign advance       = !(s2_valid_reg && q_full);
    assign pair_in.ready = advance;

    always_comb
    begin
        mag_next[0] = abs_diff(pair_in.payload.own_x, pair_in.payload.neighbour_x);
        mag_next[1] = abs_diff(pair_in.payload.own_y, pair_in.payload.neighbour_y);
        mag_next[2] = abs_diff(pair_in.payload.own_z, pair_in.payload.neighbour_z);
    end

    logic s1_first_reg, s1_last_reg, s2_first_reg, s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pair_in.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_mag_reg[k] <= mag_next[k];
                s2_sq_reg[k]  <= SQ_W'(s1_mag_reg[k]) * SQ_W'(s1_mag_reg[k]);
            end
            s1_first_reg <= pair_in.payload.first_pair;
            s1_last_reg  <= pair_in.payload.last_pair;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Exact squared distance; a sum past 64 bits is far outside any radius
    assign dist2    = D2_W'(s2_sq_reg[0]) + D2_W'(s2_sq_reg[1]) + D2_W'(s2_sq_reg[2]);
    assign in_range = dist2 < D2_W'(radius_sq);

    always_comb
    begin
        push.valid         = s2_valid_reg && !q_full;
        push.term.h        = radius_sq - dist2[sda_pkg::RADIUS_W-1:0];
        push.term.term_ok  = in_range;
        push.term.is_first = s2_first_reg;
        push.term.is_last  = s2_last_reg;
    end

endmodule

`default_nettype wire

// File: hdl/sda_queue.sv
`default_nettype none

module sda_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sda_pkg::sda_qpush_t push,
    output logic                     full,
    output sda_pkg::sda_qhead_t      head,
    input  wire logic                pop
);

    sda_pkg::sda_term_t               mem [0:sda_pkg::QUEUE_DEPTH-1];
    logic [sda_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sda_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sda_pkg::QCNT_W-1:0]       count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full       = count_reg == sda_pkg::QCNT_W'(sda_pkg::QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.term  = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.term;
    end

endmodule

`default_nettype wire

// File: hdl/sda_back.sv
`default_nettype none

module sda_back #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sda_pkg::sda_cfg_regs_t cfg_regs,
    input  wire sda_pkg::sda_qhead_t    head,
    output logic                        pop,
    sda_stream_if.source                result_out
);

    localparam int LW         = sda_pkg::LIMB_W;
    localparam int NPROD      = 8;
    localparam int CUBE_W     = NPROD * LW;
    localparam int CUBE_SHIFT = 6 * COORD_FRAC_BITS - 64;
    localparam int AW         = sda_pkg::ACC_W;
    localparam int FULL_W     = 3 * LW;

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_SQ   = 7'b0000010,
        B_CU   = 7'b0000100,
        B_ACC  = 7'b0001000,
        B_FIN  = 7'b0010000,
        B_SCL  = 7'b0100000,
        B_OUT  = 7'b1000000
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic [1:0]               i_reg, i_next;
    logic                     j_reg, j_next;
    logic [LW-1:0]            carry_reg;
    logic [sda_pkg::RADIUS_W-1:0] h_reg;
    logic                     last_reg;
    logic [LW-1:0]            sq_reg   [0:3];
    logic [LW-1:0]            prod_reg [0:NPROD-1];
    logic [AW-1:0]            sum_reg;
    logic                     clip_reg;
    logic [AW-1:0]            v_reg;
    logic                     fin_clip_reg;
    logic                     out_valid_reg;
    sda_pkg::sda_result_t     out_data_reg;

    logic [LW-1:0]            h_lo, h_hi, mul_x, mul_y, r_rd, carry_in;
    logic [2*LW-1:0]          t;
    logic [2:0]               ij, ij1;
    logic                     row_end, phase_end, out_load;
    logic [CUBE_W-1:0]        cube, cube_sh;
    logic [AW-1:0]            term;
    logic                     term_clip;
    logic [AW:0]              acc_sum, fin_sum;
    logic [FULL_W-1:0]        full_prod;
    logic                     scale_over;

    assign h_lo = h_reg[LW-1:0];
    assign h_hi = LW'(h_reg[sda_pkg::RADIUS_W-1:LW]);

    // Operand select for the shared 32x32 multiplier
    always_comb
    begin
        case (state_reg)
            B_SQ:    mul_x = i_reg[0] ? h_hi : h_lo;
            B_CU:    mul_x = sq_reg[i_reg];
            B_SCL:   mul_x = i_reg[0] ? v_reg[AW-1:LW] : v_reg[LW-1:0];
            default: mul_x = '0;
        endcase
        mul_y = (state_reg == B_SCL) ? cfg_regs.density_gain : (j_reg ? h_hi : h_lo);
    end

    assign ij       = 3'(i_reg) + 3'(j_reg);
    assign ij1      = ij + 3'd1;
    assign r_rd     = (state_reg == B_SQ) ? sq_reg[ij[1:0]] : prod_reg[ij];
    assign carry_in = j_reg ? carry_reg : '0;
    assign t        = (2*LW)'(mul_x) * (2*LW)'(mul_y) + (2*LW)'(r_rd) + (2*LW)'(carry_in);
    assign row_end  = (state_reg == B_SCL) || j_reg;

    always_comb
    begin
        case (state_reg)
            B_SQ:    phase_end = row_end && (i_reg == 2'd1);
            B_CU:    phase_end = row_end && (i_reg == 2'd3);
            B_SCL:   phase_end = i_reg == 2'd1;
            default: phase_end = 1'b0;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < NPROD; k++)
            cube[k*LW +: LW] = prod_reg[k];
    end

    assign cube_sh    = cube >> CUBE_SHIFT;
    assign term_clip  = |cube_sh[CUBE_W-1:AW];
    assign term       = term_clip ? '1 : cube_sh[AW-1:0];
    assign acc_sum    = {1'b0, sum_reg} + {1'b0, term};
    assign fin_sum    = {1'b0, sum_reg} + {1'b0, cfg_regs.kernel_offset};
    assign full_prod  = {prod_reg[2], prod_reg[1], prod_reg[0]};
    assign scale_over = |full_prod[FULL_W-1:AW+sda_pkg::GAIN_FRAC];
    assign out_load   = (state_reg == B_OUT) && (!out_valid_reg || result_out.ready);
    assign pop        = (state_reg == B_IDLE) && head.valid;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg) inside
            B_IDLE:
            begin
                i_next = '0;
                j_next = 1'b0;
                if (head.valid)
                begin
                    if (head.term.term_ok)
                        state_next = B_SQ;
                    else if (head.term.is_last)
                        state_next = B_FIN;
                end
            end
            B_SQ, B_CU, B_SCL:
            begin
                if (row_end)
                begin
                    j_next = 1'b0;
                    i_next = phase_end ? 2'd0 : i_reg + 2'd1;
                end
                else
                    j_next = 1'b1;
                if (phase_end)
                begin
                    case (state_reg)
                        B_SQ:    state_next = B_CU;
                        B_CU:    state_next = B_ACC;
                        default: state_next = B_OUT;
                    endcase
                end
            end
            B_ACC:   state_next = last_reg ? B_FIN : B_IDLE;
            B_FIN:   state_next = B_SCL;
            B_OUT:
            begin
                if (out_load)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            i_reg         <= '0;
            j_reg         <= 1'b0;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (pop && head.term.is_first)
            begin
                sum_reg  <= '0;
                clip_reg <= 1'b0;
            end
            else if (state_reg == B_ACC)
            begin
                sum_reg  <= acc_sum[AW] ? '1 : acc_sum[AW-1:0];
                clip_reg <= clip_reg | term_clip | acc_sum[AW];
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            h_reg    <= head.term.h;
            last_reg <= head.term.is_last;
            for (int k = 0; k < 4; k++)
                sq_reg[k] <= '0;
        end
        if (state_reg == B_SQ)
        begin
            sq_reg[ij[1:0]] <= t[LW-1:0];
            if (row_end)
                sq_reg[ij1[1:0]] <= t[2*LW-1:LW];
            else
                carry_reg <= t[2*LW-1:LW];
            if (phase_end)
            begin
                for (int k = 0; k < NPROD; k++)
                    prod_reg[k] <= '0;
            end
        end
        if ((state_reg == B_CU) || (state_reg == B_SCL))
        begin
            prod_reg[ij] <= t[LW-1:0];
            if (row_end)
                prod_reg[ij1] <= t[2*LW-1:LW];
            else
                carry_reg <= t[2*LW-1:LW];
        end
        if (state_reg == B_FIN)
        begin
            v_reg        <= fin_sum[AW] ? '1 : fin_sum[AW-1:0];
            fin_clip_reg <= clip_reg | fin_sum[AW];
            for (int k = 0; k < NPROD; k++)
                prod_reg[k] <= '0;
        end
        if (out_load)
        begin
            out_data_reg.density   <= scale_over ? '1
                                                 : full_prod[AW+sda_pkg::GAIN_FRAC-1:
                                                             sda_pkg::GAIN_FRAC];
            out_data_reg.saturated <= fin_clip_reg | scale_over;
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = out_data_reg;

endmodule

`default_nettype wire

// File: hdl/sph_density_accumulator.sv
`default_nettype none

// SPH density accumulator. Stream the neighbour pairs of one particle on
// pair_in: first_pair clears the running sum and clip flag, and last_pair
// makes the block emit one request on result_out holding
// ((sum + kernel_offset) * density_gain) >> 16, saturated, with a flag set if
// any step clipped since the last clear. Each pair within radius adds
// ((radius_sq - dist2)^3 >> (6*COORD_FRAC_BITS - 64)) to the saturating sum.
// The front end takes one pair per cycle while the queue has room, through a
// two-stage distance pipe into a four-entry queue; the back end pops a pair
// outside the radius without using its multiplier, and for a pair inside it
// runs 4 + 8 steps of its one shared 32x32 multiplier forming the cube; a
// last pair then gets the offset, the two-step gain multiply and the output load.
// That multiplier sets the sustained rate. A result waits in an output register
// while the next pairs are already taken in. Write configuration (radius_sq,
// kernel_offset, density_gain, indexes 0 to 2) only while the block is idle;
// the config port is always ready and ignores other indexes.
module sph_density_accumulator #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    sda_stream_if.sink      cfg,
    sda_stream_if.sink      pair_in,
    sda_stream_if.source    result_out
);

    sda_pkg::sda_cfg_regs_t cfg_regs_reg;
    sda_pkg::sda_qpush_t    q_push;
    sda_pkg::sda_qhead_t    q_head;
    logic                   q_full;
    logic                   q_pop;

    // Config writes are always taken; unknown indexes drop silently
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.radius_sq     <= '0;
            cfg_regs_reg.kernel_offset <= '0;
            cfg_regs_reg.density_gain  <= sda_pkg::GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                sda_pkg::REG_RADIUS_SQ:
                    cfg_regs_reg.radius_sq <= cfg.payload.data[sda_pkg::RADIUS_W-1:0];
                sda_pkg::REG_KERNEL_OFFSET:
                    cfg_regs_reg.kernel_offset <= cfg.payload.data;
                sda_pkg::REG_DENSITY_GAIN:
                    cfg_regs_reg.density_gain <= cfg.payload.data[sda_pkg::GAIN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Front: distance pipe and radius test, one pair per cycle while the queue has room
    sda_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .radius_sq (cfg_regs_reg.radius_sq),
        .pair_in   (pair_in),
        .q_full    (q_full),
        .push      (q_push)
    );

    // Decouple the fast front from the multi-cycle back
    sda_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    // Back: cube term, accumulation, offset and gain
    sda_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_regs_reg),
        .head       (q_head),
        .pop        (q_pop),
        .result_out (result_out)
    );

    // The front never offers a pair the queue cannot hold
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> !q_full)
        else $error("front pushed into a full queue");

    // The back only dequeues a pair that is there
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("back popped an empty queue");

    // A stalled front holds its ready low until the queue frees an entry
    a_stall_until_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (!pair_in.ready && !q_pop) |=> !pair_in.ready)
        else $error("front resumed without queue space");

endmodule

`default_nettype wire

// File: tb/sph_density_accumulator_test.sv
`timescale 1ns / 100ps

module sph_density_accumulator_test;

    localparam int COORD_FRAC   = 24;
    // Right shift that brings the cube of an h with 2F fraction bits to Q0.64
    localparam int CUBE_SHIFT   = 6 * COORD_FRAC - 64;
    localparam int QUIET_LIMIT  = 4000;
    // Up to seven in-radius pairs held in the front pipe, the queue and the
    // back end, the finish of a last pair, and some margin
    localparam int DRAIN_CYCLES = 160;

    localparam logic [sda_pkg::RADIUS_W-1:0] RADIUS_MAX = '1;
    localparam logic [sda_pkg::ACC_W-1:0]    ACC_MAX    = '1;
    localparam logic [sda_pkg::GAIN_W-1:0]   GAIN_MAX   = '1;

    logic clk;
    logic rst_n;

    sda_stream_if #(.PAYLOAD_T(sda_pkg::sda_cfg_t))    cfg_if ();
    sda_stream_if #(.PAYLOAD_T(sda_pkg::sda_pair_t))   pair_if ();
    sda_stream_if #(.PAYLOAD_T(sda_pkg::sda_result_t)) res_if ();

    sph_density_accumulator #(
        .COORD_FRAC_BITS (COORD_FRAC)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .pair_in    (pair_if),
        .result_out (res_if)
    );

    // Shadow copy of the register file, updated when a write request is taken
    logic [sda_pkg::RADIUS_W-1:0] cfg_radius_sq;
    logic [sda_pkg::ACC_W-1:0]    cfg_offset;
    logic [sda_pkg::GAIN_W-1:0]   cfg_gain;

    // Shadow of the running per-particle state
    logic [sda_pkg::ACC_W-1:0]    run_sum;
    logic                         run_clip;

    sda_pkg::sda_pair_t   pairs_waiting[$];
    sda_pkg::sda_result_t density_due[$];

    int pairs_queued;
    int pairs_taken;
    int densities_seen;
    int mismatch_count;
    int quiet_cycles;
    int idle_pct;
    int stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Density predictor
    // ------------------------------------------------------------------

    // Square of the exact 33-bit difference of two coordinates
    function automatic logic [63:0] square_of_gap(logic signed [sda_pkg::COORD_W-1:0] a,
                                                  logic signed [sda_pkg::COORD_W-1:0] b);
        logic [32:0] gap;
        logic [31:0] mag;
        gap = {a[sda_pkg::COORD_W-1], a} - {b[sda_pkg::COORD_W-1], b};
        mag = gap[32] ? 32'(-gap) : gap[31:0];
        return {32'b0, mag} * {32'b0, mag};
    endfunction

    // Unsigned add that clamps at all ones and flags the clamp
    function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b,
                                                inout logic clip);
        logic [64:0] total;
        total = {1'b0, a} + {1'b0, b};
        if (total[64])
        begin
            clip = 1'b1;
            return ACC_MAX;
        end
        return total[63:0];
    endfunction

    // Fold one taken pair into the shadow state; queue a density on last_pair
    task automatic fold_pair(sda_pkg::sda_pair_t p);
        logic [63:0]                  dist2;
        logic [63:0]                  term;
        logic [63:0]                  total;
        logic [sda_pkg::RADIUS_W-1:0] h;
        logic [191:0]                 cube;
        logic [95:0]                  product;
        logic                         far;
        logic                         clip;
        sda_pkg::sda_result_t         r;

        if (p.first_pair)
        begin
            run_sum  = '0;
            run_clip = 1'b0;
        end

        // A clamped distance is never inside the radius
        far   = 1'b0;
        dist2 = add_clamped(square_of_gap(p.own_x, p.neighbour_x),
                            square_of_gap(p.own_y, p.neighbour_y), far);
        dist2 = add_clamped(dist2, square_of_gap(p.own_z, p.neighbour_z), far);

        if (!far && dist2 < 64'(cfg_radius_sq))
        begin
            h    = cfg_radius_sq - dist2[sda_pkg::RADIUS_W-1:0];
            cube = {144'b0, h} * {144'b0, h} * {144'b0, h};
            cube = cube >> CUBE_SHIFT;
            clip = 1'b0;
            if (|cube[191:64])
            begin
                term = ACC_MAX;
                clip = 1'b1;
            end
            else
                term = cube[63:0];
            run_sum = add_clamped(run_sum, term, clip);
            if (clip)
                run_clip = 1'b1;
        end

        if (p.last_pair)
        begin
            clip    = run_clip;
            total   = add_clamped(run_sum, cfg_offset, clip);
            product = {32'b0, total} * {64'b0, cfg_gain};
            if (|product[95:80])
            begin
                clip      = 1'b1;
                r.density = ACC_MAX;
            end
            else
                r.density = product[79:16];
            r.saturated = clip;
            density_due.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("density %0d: %s mismatch, got %h want %h",
                 densities_seen, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Pair driver: present the next pending request, fold each taken one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : pair_driver
        if (!rst_n)
            pair_if.valid <= 1'b0;
        else
        begin
            if (pair_if.valid && pair_if.ready)
            begin
                fold_pair(pair_if.payload);
                pairs_taken++;
            end
            // Hold the request until taken; otherwise load the next or idle
            if (!pair_if.valid || pair_if.ready)
            begin
                if (pairs_waiting.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    pair_if.valid   <= 1'b1;
                    pair_if.payload <= pairs_waiting.pop_front();
                end
                else
                    pair_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each density against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : density_monitor
        sda_pkg::sda_result_t want;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (density_due.size() == 0)
                    report_mismatch("unexpected result", res_if.payload.density, '0);
                else
                begin
                    want = density_due.pop_front();
                    if (res_if.payload.density !== want.density)
                        report_mismatch("density", res_if.payload.density, want.density);
                    if (res_if.payload.saturated !== want.saturated)
                        report_mismatch("saturated", 64'(res_if.payload.saturated),
                                        64'(want.saturated));
                end
                densities_seen++;
            end
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Abort when no request moves on any channel for too long
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((cfg_if.valid && cfg_if.ready) || (pair_if.valid && pair_if.ready) ||
                (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register; leave valid high so back-to-back writes stay clean
    task automatic write_reg(logic [sda_pkg::REG_IDX_W-1:0] idx,
                             logic [sda_pkg::CFG_DATA_W-1:0] value);
        sda_pkg::sda_cfg_t req;
        req.index = idx;
        req.data  = value;
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= req;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            sda_pkg::REG_RADIUS_SQ:     cfg_radius_sq = value[sda_pkg::RADIUS_W-1:0];
            sda_pkg::REG_KERNEL_OFFSET: cfg_offset    = value;
            sda_pkg::REG_DENSITY_GAIN:  cfg_gain      = value[sda_pkg::GAIN_W-1:0];
            default:                    ;
        endcase
    endtask

    task automatic program_regs(logic [sda_pkg::RADIUS_W-1:0] radius,
                                logic [sda_pkg::ACC_W-1:0] offset,
                                logic [sda_pkg::GAIN_W-1:0] gain);
        write_reg(sda_pkg::REG_RADIUS_SQ, 64'(radius));
        write_reg(sda_pkg::REG_KERNEL_OFFSET, offset);
        write_reg(sda_pkg::REG_DENSITY_GAIN, 64'(gain));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic program_random();
        logic [63:0]                  raw;
        logic [sda_pkg::RADIUS_W-1:0] radius;
        logic [sda_pkg::ACC_W-1:0]    offset;
        logic [sda_pkg::GAIN_W-1:0]   gain;
        raw    = {$urandom(), $urandom()};
        radius = raw[63:16] >> $urandom_range(0, 36);
        offset = {$urandom(), $urandom()} >> $urandom_range(0, 63);
        if ($urandom_range(3) == 0)
            gain = $urandom();
        else
            gain = $urandom_range(0, 32'h0004_0000);
        program_regs(radius, offset, gain);
    endtask

    task automatic push_pair(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic first, logic last);
        sda_pkg::sda_pair_t p;
        p.own_x       = ox;
        p.own_y       = oy;
        p.own_z       = oz;
        p.neighbour_x = nx;
        p.neighbour_y = ny;
        p.neighbour_z = nz;
        p.first_pair  = first;
        p.last_pair   = last;
        pairs_waiting.push_back(p);
        pairs_queued++;
    endtask

    // One particle: neighbours mostly near the particle at a random spread,
    // a few anywhere; now and then drop first_pair or last_pair
    task automatic queue_particle(int n_pairs, bit close_out);
        logic [31:0] cx, cy, cz;
        logic [31:0] nx, ny, nz;
        logic        first, last;
        int          spread;
        cx     = $urandom();
        cy     = $urandom();
        cz     = $urandom();
        spread = $urandom_range(8, 31);
        for (int i = 0; i < n_pairs; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                nx = $urandom();
                ny = $urandom();
                nz = $urandom();
            end
            else
            begin
                nx = cx + ($signed($urandom()) >>> spread);
                ny = cy + ($signed($urandom()) >>> spread);
                nz = cz + ($signed($urandom()) >>> spread);
            end
            first = ((i == 0) && $urandom_range(19) != 0) || $urandom_range(49) == 0;
            last  = ((i == n_pairs - 1) && (close_out || $urandom_range(19) != 0)) ||
                    $urandom_range(49) == 0;
            push_pair(cx, cy, cz, nx, ny, nz, first, last);
        end
    endtask

    // Wait until every pair is taken and every density has come back
    task automatic wait_drained();
        while (pairs_taken != pairs_queued || density_due.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then let the back end finish any pair that makes no result
    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int n_items, int idle, int stall, bit pressure);
        int n_pairs;
        int queued;
        idle_pct  = idle;
        stall_pct = stall;
        queued    = 0;
        while (queued < n_items)
        begin
            n_pairs = $urandom_range(1, 8);
            queue_particle(n_pairs, queued + n_pairs >= n_items);
            queued += n_pairs;
            // Hold the sender back until the particle is fully answered
            if (pressure)
                wait_drained();
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        pair_if.valid   = 1'b0;
        pair_if.payload = '0;
        res_if.ready    = 1'b0;
        cfg_radius_sq   = '0;
        cfg_offset      = '0;
        cfg_gain        = sda_pkg::GAIN_RESET;
        run_sum         = '0;
        run_clip        = 1'b0;
        pairs_queued    = 0;
        pairs_taken     = 0;
        densities_seen  = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        idle_pct        = 0;
        stall_pct       = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: zero radius lets nothing in, density stays zero
        push_pair('0, '0, '0, '0, '0, '0, 1'b1, 1'b1);
        settle();

        // Widest radius: coincident pairs give the largest term, two of
        // them clip the sum; extreme coordinates clamp the distance
        program_regs(RADIUS_MAX, '0, sda_pkg::GAIN_RESET);
        push_pair('0, '0, '0, '0, '0, '0, 1'b1, 1'b1);
        push_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0);
        push_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
        push_pair('0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
        push_pair('0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
        // No first_pair after a last one: the clipped sum carries on
        push_pair('0, '0, '0, 32'h7fff_ffff, '0, '0, 1'b0, 1'b1);
        push_pair(32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                  32'h0110_0000, 32'h00f0_0000, 32'h0100_0000, 1'b1, 1'b1);
        settle();

        // Radius boundary: a distance equal to the radius adds nothing;
        // full offset and gain clip the offset add and the scaling
        program_regs(sda_pkg::RADIUS_W'(1) << 46, ACC_MAX, GAIN_MAX);
        push_pair('0, '0, '0, 32'h0080_0000, '0, '0, 1'b1, 1'b1);
        push_pair('0, '0, '0, 32'h0040_0000, '0, '0, 1'b1, 1'b1);
        settle();

        // Zero gain wipes the density
        program_regs(sda_pkg::RADIUS_W'(1) << 40, '0, '0);
        push_pair(32'hff00_0000, 32'hff00_0000, 32'hff00_0000,
                  32'hff00_0000, 32'hff00_0000, 32'hff00_0000, 1'b1, 1'b1);
        settle();

        // Smallest gain step gives the sum shifted right by 16 over a three-pair particle
        program_regs(sda_pkg::RADIUS_W'(1) << 46, '0, 32'd1);
        push_pair(32'hff00_0000, 32'hff00_0000, 32'hff00_0000,
                  32'hff40_0000, 32'hff00_0000, 32'hff00_0000, 1'b1, 1'b0);
        push_pair(32'hff00_0000, 32'hff00_0000, 32'hff00_0000,
                  32'hff00_0000, 32'hfec0_0000, 32'hff00_0000, 1'b0, 1'b0);
        push_pair(32'hff00_0000, 32'hff00_0000, 32'hff00_0000,
                  32'hff00_0000, 32'hff00_0000, 32'hff10_0000, 1'b0, 1'b1);
        settle();

        // Random particles across idling patterns and register settings
        program_random();
        run_phase(350, 0, 0, 1'b0);
        program_random();
        run_phase(350, 82, 0, 1'b0);
        program_random();
        run_phase(350, 0, 82, 1'b0);
        program_random();
        run_phase(300, 37, 37, 1'b0);
        program_random();
        run_phase(200, 37, 37, 1'b1);
        program_regs(RADIUS_MAX, ACC_MAX, GAIN_MAX);
        run_phase(200, 0, 0, 1'b0);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hdl/sda_pkg.sv
hdl/sda_stream_if.sv
hdl/sda_front.sv
hdl/sda_queue.sv
hdl/sda_back.sv
hdl/sph_density_accumulator.sv
tb/sph_density_accumulator_test.sv
